/* design/gtg_pkg.sv */
// Shared types, constants and tables for the go-to-goal controller.
// Used by gtg_cordic, go_to_goal_controller and the testbench; depends on nothing.
package gtg_pkg;

    localparam int CORDIC_STEPS_DEF = 16;

    localparam int ANGLE_W = 21;
    localparam int CORD_W  = 36;

    typedef logic signed [ANGLE_W-1:0] t_angle;
    typedef logic signed [CORD_W-1:0]  t_cord;

    localparam logic signed [21:0] ANG_PI     = 22'sd205887;
    localparam logic signed [21:0] ANG_TWO_PI = 22'sd411775;

    // Register reset values, unsigned Q4.16.
    localparam logic [19:0] LIN_GAIN_RST  = 20'd13107;
    localparam logic [19:0] HEAD_GAIN_RST = 20'd17039;
    localparam logic [19:0] LIN_LIM_RST   = 20'd45875;
    localparam logic [19:0] ANG_LIM_RST   = 20'd39322;
    localparam logic [19:0] TOL_RST       = 20'd3277;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_GOAL_X    = 3'd0;
    localparam logic [2:0] REG_GOAL_Y    = 3'd1;
    localparam logic [2:0] REG_LIN_GAIN  = 3'd2;
    localparam logic [2:0] REG_HEAD_GAIN = 3'd3;
    localparam logic [2:0] REG_LIN_LIM   = 3'd4;
    localparam logic [2:0] REG_ANG_LIM   = 3'd5;
    localparam logic [2:0] REG_TOL       = 3'd6;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MX,
        S_MY,
        S_MS,
        S_SQRT,
        S_DIST,
        S_BSTART,
        S_BWAIT,
        S_QUAT,
        S_YCHK,
        S_YWAIT,
        S_ERR,
        S_MA,
        S_MB,
        S_ML
    } t_state;

    // Arctangent of 2^-i in signed Q4.16 radians.
    function automatic t_angle atan_entry(input logic [4:0] idx);
        t_angle v;
        case (idx)
            5'd0:    v = 21'sd51472;
            5'd1:    v = 21'sd30386;
            5'd2:    v = 21'sd16055;
            5'd3:    v = 21'sd8150;
            5'd4:    v = 21'sd4091;
            5'd5:    v = 21'sd2047;
            5'd6:    v = 21'sd1024;
            5'd7:    v = 21'sd512;
            5'd8:    v = 21'sd256;
            5'd9:    v = 21'sd128;
            5'd10:   v = 21'sd64;
            5'd11:   v = 21'sd32;
            5'd12:   v = 21'sd16;
            5'd13:   v = 21'sd8;
            5'd14:   v = 21'sd4;
            5'd15:   v = 21'sd2;
            5'd16:   v = 21'sd1;
            default: v = 21'sd0;
        endcase
        return v;
    endfunction

endpackage

/* design/gtg_cordic.sv */
// Iterative vectoring CORDIC giving atan2(y, x) in signed Q4.16 radians, one step a cycle.
// Depends on gtg_pkg for the angle types and the arctangent table.
module gtg_cordic #(
    parameter int STEPS = gtg_pkg::CORDIC_STEPS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  gtg_pkg::t_cord i_x,
    input  gtg_pkg::t_cord i_y,
    output logic           o_done,
    output gtg_pkg::t_angle o_angle
);

    localparam int CW = $clog2(STEPS);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    gtg_pkg::t_cord   r_x;
    gtg_pkg::t_cord   r_y;
    gtg_pkg::t_angle  r_z;

    gtg_pkg::t_cord   w_sx;
    gtg_pkg::t_cord   w_sy;
    gtg_pkg::t_angle  w_tab;

    assign w_sx  = r_x >>> r_cnt;
    assign w_sy  = r_y >>> r_cnt;
    assign w_tab = gtg_pkg::atan_entry(5'(r_cnt));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= '0;
                if (i_x == '0 && i_y == '0) begin
                    // A zero vector has no direction; report zero without iterating.
                    r_z    <= '0;
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    if (i_x < 0) begin
                        r_z <= (i_y >= 0) ? gtg_pkg::t_angle'(gtg_pkg::ANG_PI)
                                          : gtg_pkg::t_angle'(-gtg_pkg::ANG_PI);
                        r_x <= -i_x;
                        r_y <= -i_y;
                    end else begin
                        r_z <= '0;
                        r_x <= i_x;
                        r_y <= i_y;
                    end
                end
            end else if (r_busy) begin
                if (r_y > 0) begin
                    r_x <= r_x + w_sy;
                    r_y <= r_y - w_sx;
                    r_z <= r_z + w_tab;
                end else begin
                    r_x <= r_x - w_sy;
                    r_y <= r_y + w_sx;
                    r_z <= r_z - w_tab;
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done  = r_done;
    assign o_angle = r_z;

endmodule

/* design/go_to_goal_controller.sv */
// Go-to-goal proportional controller: distance, bearing and yaw on shared units.
// Depends on gtg_pkg and gtg_cordic.
// The result register is loaded straight from idle when done is latched or the remembered
// distance is within tolerance; otherwise an item takes at most a 32-step square root,
// two CORDIC runs (one when the yaw is forced to zero) and twelve multiplier passes.
// One item at a time; the next is taken once the result has been collected.
// Synchronous active-low reset restores register defaults and clears the done latch.
module go_to_goal_controller #(
    parameter int CORDIC_STEPS = gtg_pkg::CORDIC_STEPS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // position_x[31:0], position_y[63:32], quat_x[79:64], quat_y[95:80],
    // quat_z[111:96], quat_w[127:112]
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // linear_cmd[19:0], angular_cmd[40:20], goal_distance[72:41], goal_done[73]
    output logic [79:0]  m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    gtg_pkg::t_state r_state;
    gtg_pkg::t_state n_state;

    // Configuration registers.
    logic signed [31:0] r_goal_x;
    logic signed [31:0] r_goal_y;
    logic [19:0]        r_lg;
    logic [19:0]        r_hg;
    logic [19:0]        r_llim;
    logic [19:0]        r_alim;
    logic [19:0]        r_tol;

    // Controller state.
    logic [31:0] r_last;
    logic        r_have;
    logic        r_done_latch;

    // Working registers.
    logic signed [32:0] r_dx;
    logic signed [32:0] r_dy;
    logic signed [15:0] r_qx, r_qy, r_qz, r_qw;
    logic signed [65:0] r_prod;
    logic [63:0]        r_acc;
    logic [63:0]        r_rem;
    logic [63:0]        r_root;
    logic [63:0]        r_one;
    logic [31:0]        r_dist;
    logic [3:0]         r_cnt;
    logic signed [31:0] r_n, r_s, r_m, r_t;
    gtg_pkg::t_angle    r_bear;
    gtg_pkg::t_angle    r_yaw;
    logic signed [21:0] r_err;

    // Result register.
    logic               r_ovalid;
    logic [19:0]        r_lin;
    logic signed [20:0] r_ang;
    logic [31:0]        r_odist;
    logic               r_odone;

    logic               w_in_acc;
    logic               w_wr;
    logic signed [32:0] w_ma;
    logic signed [32:0] w_mb;
    logic               w_cstart;
    gtg_pkg::t_cord     w_cx;
    gtg_pkg::t_cord     w_cy;
    logic               w_cdone;
    gtg_pkg::t_angle    w_cangle;
    logic [31:0]        w_adx;
    logic [31:0]        w_ady;
    logic [64:0]        w_sum;
    logic [63:0]        w_trial;
    logic [63:0]        w_root_n;
    logic signed [31:0] w_p;
    logic signed [33:0] w_m2;
    logic signed [33:0] w_m2abs;
    logic               w_yaw_zero;
    logic signed [21:0] w_bearx;
    logic signed [21:0] w_e;
    logic signed [65:0] w_pa;
    logic signed [65:0] w_lim;
    logic [31:0]        w_tol32;

    assign pready   = 1'b1;
    assign w_wr     = psel & penable & pwrite;
    assign w_in_acc = s_axis_tvalid & s_axis_tready;
    assign s_axis_tready = (r_state == gtg_pkg::S_IDLE) && !r_ovalid;
    assign w_tol32  = {12'd0, r_tol};

    always_comb begin
        case (paddr[4:2])
            gtg_pkg::REG_GOAL_X:    prdata = r_goal_x;
            gtg_pkg::REG_GOAL_Y:    prdata = r_goal_y;
            gtg_pkg::REG_LIN_GAIN:  prdata = {12'd0, r_lg};
            gtg_pkg::REG_HEAD_GAIN: prdata = {12'd0, r_hg};
            gtg_pkg::REG_LIN_LIM:   prdata = {12'd0, r_llim};
            gtg_pkg::REG_ANG_LIM:   prdata = {12'd0, r_alim};
            gtg_pkg::REG_TOL:       prdata = {12'd0, r_tol};
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x <= '0;
            r_goal_y <= '0;
            r_lg     <= gtg_pkg::LIN_GAIN_RST;
            r_hg     <= gtg_pkg::HEAD_GAIN_RST;
            r_llim   <= gtg_pkg::LIN_LIM_RST;
            r_alim   <= gtg_pkg::ANG_LIM_RST;
            r_tol    <= gtg_pkg::TOL_RST;
        end else if (w_wr) begin
            case (paddr[4:2])
                gtg_pkg::REG_GOAL_X:    r_goal_x <= pwdata;
                gtg_pkg::REG_GOAL_Y:    r_goal_y <= pwdata;
                gtg_pkg::REG_LIN_GAIN:  r_lg     <= pwdata[19:0];
                gtg_pkg::REG_HEAD_GAIN: r_hg     <= pwdata[19:0];
                gtg_pkg::REG_LIN_LIM:   r_llim   <= pwdata[19:0];
                gtg_pkg::REG_ANG_LIM:   r_alim   <= pwdata[19:0];
                gtg_pkg::REG_TOL:       r_tol    <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    // Shared datapath helpers.
    assign w_adx    = r_dx < 0 ? 32'(-r_dx) : 32'(r_dx);
    assign w_ady    = r_dy < 0 ? 32'(-r_dy) : 32'(r_dy);
    assign w_sum    = {1'b0, r_acc} + {1'b0, r_prod[63:0]};
    assign w_trial  = r_root + r_one;
    assign w_root_n = (r_rem >= w_trial) ? ((r_root >> 1) + r_one) : (r_root >> 1);
    assign w_p      = r_prod[31:0];
    assign w_m2     = 34'(r_m) <<< 1;
    assign w_m2abs  = w_m2 < 0 ? -w_m2 : w_m2;
    assign w_yaw_zero = w_m2abs >= 34'(r_n);
    assign w_bearx  = (w_cangle < 0) ? 22'(w_cangle) + gtg_pkg::ANG_TWO_PI : 22'(w_cangle);
    assign w_e      = 22'(r_bear) - 22'(r_yaw);
    assign w_pa     = r_prod >>> 16;
    assign w_lim    = $signed({46'd0, r_alim});

    // Next state, multiplier operands and CORDIC requests.
    always_comb begin
        n_state  = r_state;
        w_ma     = '0;
        w_mb     = '0;
        w_cstart = 1'b0;
        w_cx     = 36'(r_dx);
        w_cy     = 36'(r_dy);
        case (r_state)
            gtg_pkg::S_IDLE: begin
                if (w_in_acc && !r_done_latch && !(r_have && r_last <= w_tol32)) begin
                    n_state = gtg_pkg::S_MX;
                end
            end
            gtg_pkg::S_MX: begin
                w_ma    = $signed({1'b0, w_adx});
                w_mb    = $signed({1'b0, w_adx});
                n_state = gtg_pkg::S_MY;
            end
            gtg_pkg::S_MY: begin
                w_ma    = $signed({1'b0, w_ady});
                w_mb    = $signed({1'b0, w_ady});
                n_state = gtg_pkg::S_MS;
            end
            gtg_pkg::S_MS: begin
                n_state = w_sum[64] ? gtg_pkg::S_DIST : gtg_pkg::S_SQRT;
            end
            gtg_pkg::S_SQRT: begin
                if (r_one[0]) begin
                    n_state = gtg_pkg::S_DIST;
                end
            end
            gtg_pkg::S_DIST: begin
                if (!r_have && r_dist <= w_tol32) begin
                    n_state = gtg_pkg::S_IDLE;
                end else begin
                    n_state = gtg_pkg::S_BSTART;
                end
            end
            gtg_pkg::S_BSTART: begin
                w_cstart = 1'b1;
                n_state  = gtg_pkg::S_BWAIT;
            end
            gtg_pkg::S_BWAIT: begin
                if (w_cdone) begin
                    n_state = gtg_pkg::S_QUAT;
                end
            end
            gtg_pkg::S_QUAT: begin
                case (r_cnt[2:0])
                    3'd0: begin w_ma = 33'(r_qy); w_mb = 33'(r_qy); end
                    3'd1: begin w_ma = 33'(r_qz); w_mb = 33'(r_qz); end
                    3'd2: begin w_ma = 33'(r_qx); w_mb = 33'(r_qx); end
                    3'd3: begin w_ma = 33'(r_qw); w_mb = 33'(r_qw); end
                    3'd4: begin w_ma = 33'(r_qx); w_mb = 33'(r_qz); end
                    3'd5: begin w_ma = 33'(r_qw); w_mb = 33'(r_qy); end
                    3'd6: begin w_ma = 33'(r_qx); w_mb = 33'(r_qy); end
                    default: begin w_ma = 33'(r_qw); w_mb = 33'(r_qz); end
                endcase
                if (r_cnt == 4'd8) begin
                    n_state = gtg_pkg::S_YCHK;
                end
            end
            gtg_pkg::S_YCHK: begin
                w_cx = 36'(r_n) - (36'(r_s) <<< 1);
                w_cy = 36'(r_t) <<< 1;
                if (w_yaw_zero) begin
                    n_state = gtg_pkg::S_ERR;
                end else begin
                    w_cstart = 1'b1;
                    n_state  = gtg_pkg::S_YWAIT;
                end
            end
            gtg_pkg::S_YWAIT: begin
                if (w_cdone) begin
                    n_state = gtg_pkg::S_ERR;
                end
            end
            gtg_pkg::S_ERR: begin
                n_state = gtg_pkg::S_MA;
            end
            gtg_pkg::S_MA: begin
                w_ma    = $signed({13'd0, r_hg});
                w_mb    = 33'(r_err);
                n_state = gtg_pkg::S_MB;
            end
            gtg_pkg::S_MB: begin
                w_ma    = $signed({13'd0, r_lg});
                w_mb    = $signed({1'b0, r_dist});
                n_state = gtg_pkg::S_ML;
            end
            gtg_pkg::S_ML: begin
                n_state = gtg_pkg::S_IDLE;
            end
            default: begin
                n_state = gtg_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gtg_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    gtg_cordic #(
        .STEPS(CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cstart),
        .i_x     (w_cx),
        .i_y     (w_cy),
        .o_done  (w_cdone),
        .o_angle (w_cangle)
    );

    // The multiplier output is registered; each product is used in the cycle after its operands.
    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last       <= '0;
            r_have       <= 1'b0;
            r_done_latch <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                gtg_pkg::S_IDLE: begin
                    if (w_in_acc) begin
                        r_dx <= 33'(r_goal_x) - 33'($signed(s_axis_tdata[31:0]));
                        r_dy <= 33'(r_goal_y) - 33'($signed(s_axis_tdata[63:32]));
                        r_qx <= s_axis_tdata[79:64];
                        r_qy <= s_axis_tdata[95:80];
                        r_qz <= s_axis_tdata[111:96];
                        r_qw <= s_axis_tdata[127:112];
                        if (r_done_latch || (r_have && r_last <= w_tol32)) begin
                            // Arrived on the remembered distance, or already stopped.
                            r_done_latch <= 1'b1;
                            r_ovalid     <= 1'b1;
                            r_lin        <= '0;
                            r_ang        <= '0;
                            r_odist      <= r_last;
                            r_odone      <= 1'b1;
                        end
                    end
                end
                gtg_pkg::S_MY: begin
                    r_acc <= r_prod[63:0];
                end
                gtg_pkg::S_MS: begin
                    r_rem  <= w_sum[63:0];
                    r_root <= '0;
                    r_one  <= 64'd1 << 62;
                    if (w_sum[64]) begin
                        r_dist <= '1;
                    end
                end
                gtg_pkg::S_SQRT: begin
                    if (r_rem >= w_trial) begin
                        r_rem <= r_rem - w_trial;
                    end
                    r_root <= w_root_n;
                    r_one  <= r_one >> 2;
                    if (r_one[0]) begin
                        r_dist <= w_root_n[31:0];
                    end
                end
                gtg_pkg::S_DIST: begin
                    r_last <= r_dist;
                    r_have <= 1'b1;
                    if (!r_have && r_dist <= w_tol32) begin
                        r_done_latch <= 1'b1;
                        r_ovalid     <= 1'b1;
                        r_lin        <= '0;
                        r_ang        <= '0;
                        r_odist      <= r_dist;
                        r_odone      <= 1'b1;
                    end
                end
                gtg_pkg::S_BWAIT: begin
                    r_cnt <= '0;
                    r_n   <= '0;
                    r_s   <= '0;
                    r_m   <= '0;
                    r_t   <= '0;
                    if (w_cdone) begin
                        r_bear <= 21'(w_bearx);
                    end
                end
                gtg_pkg::S_QUAT: begin
                    r_cnt <= r_cnt + 1'b1;
                    case (r_cnt)
                        4'd1, 4'd2: begin
                            r_n <= r_n + w_p;
                            r_s <= r_s + w_p;
                        end
                        4'd3, 4'd4: r_n <= r_n + w_p;
                        4'd5:       r_m <= r_m + w_p;
                        4'd6:       r_m <= r_m - w_p;
                        4'd7, 4'd8: r_t <= r_t + w_p;
                        default: ;
                    endcase
                end
                gtg_pkg::S_YCHK: begin
                    r_yaw <= '0;
                end
                gtg_pkg::S_YWAIT: begin
                    if (w_cdone) begin
                        r_yaw <= w_cangle;
                    end
                end
                gtg_pkg::S_ERR: begin
                    r_err <= (w_e > gtg_pkg::ANG_PI) ? w_e - gtg_pkg::ANG_TWO_PI : w_e;
                end
                gtg_pkg::S_MB: begin
                    if (w_pa > w_lim) begin
                        r_ang <= 21'(w_lim);
                    end else if (w_pa < -w_lim) begin
                        r_ang <= 21'(-w_lim);
                    end else begin
                        r_ang <= 21'(w_pa);
                    end
                end
                gtg_pkg::S_ML: begin
                    r_ovalid <= 1'b1;
                    r_odist  <= r_dist;
                    r_odone  <= 1'b0;
                    if (r_prod[65:16] > {30'd0, r_llim}) begin
                        r_lin <= r_llim;
                    end else begin
                        r_lin <= r_prod[35:16];
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_odone, r_odist, r_ang, r_lin};

endmodule

/* design/gtg_checker.sv */
// Port-level checks for the go-to-goal controller, bound to the top level.
// Depends only on the top level's ports.
module gtg_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [79:0]  m_axis_tdata,
    input logic         pready
);

    // A stopped robot is never given a speed.
    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[73] |->
            m_axis_tdata[19:0] == 20'd0 && m_axis_tdata[40:20] == 21'd0)
        else $error("speed commanded with goal done");

    // No new item is taken while a result waits.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while result pending");

    // Once done has been delivered, a result valid right after that handshake must report done too.
    a_done_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tdata[73] ##1 m_axis_tvalid |->
            m_axis_tdata[73])
        else $error("done latch lost");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

endmodule

bind go_to_goal_controller gtg_checker u_gtg_checker (.*);

/* tb/go_to_goal_controller_tb.sv */
// Self-checking testbench for go_to_goal_controller: pose items go in on the slave stream,
// motion commands are checked field by field against a predictor of the controller.
// Depends on gtg_pkg and the controller RTL only.
module go_to_goal_controller_tb;

    typedef struct packed {
        logic signed [15:0] qw;
        logic signed [15:0] qz;
        logic signed [15:0] qy;
        logic signed [15:0] qx;
        logic signed [31:0] py;
        logic signed [31:0] px;
    } t_pose;

    typedef struct packed {
        logic        done;
        logic [31:0] dst;
        logic [20:0] ang;
        logic [19:0] lin;
    } t_cmd;

    typedef struct {
        t_pose pose;
        bit    typed;
        t_cmd  want;
    } t_row;

    localparam longint QPI      = 205887;
    localparam longint QTWO_PI  = 411775;
    localparam longint LIMIT_CY = 2000000;
    localparam logic signed [31:0] PMAX = 32'sh7fffffff;
    localparam logic signed [31:0] PMIN = 32'sh80000000;
    localparam longint ARCTAN [0:31] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [79:0]  m_axis_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    go_to_goal_controller u_top (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    always #10 i_clk = ~i_clk;

    // Controller copy: registers and remembered distance.
    logic [31:0] reg_copy [0:6];
    logic [31:0] prev_dist;
    bit          prev_valid;
    bit          arrived;

    t_row   pose_q [$];
    t_cmd   cmd_q [$];
    t_row   cur_row;
    int     errors = 0;
    longint cycles = 0;
    bit     calm = 1'b0;

    function automatic longint unsigned root64(longint unsigned n);
        longint unsigned res = 0;
        longint unsigned one = 64'h4000000000000000;
        while (one > n) one = one >> 2;
        while (one != 0) begin
            if (n >= res + one) begin
                n = n - (res + one);
                res = (res >> 1) + one;
            end else begin
                res = res >> 1;
            end
            one = one >> 2;
        end
        return res;
    endfunction

    function automatic longint bearing_of(longint y, longint x);
        longint z = 0;
        longint nx, ny;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? QPI : -QPI;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < gtg_pkg::CORDIC_STEPS_DEF; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += ARCTAN[i];
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= ARCTAN[i];
            end
            x = nx;
            y = ny;
        end
        return z;
    endfunction

    function automatic logic [31:0] range_to_goal(t_pose p);
        longint dx, dy;
        longint unsigned ax, ay;
        logic [64:0] sq;
        longint unsigned r;
        dx = longint'($signed(reg_copy[gtg_pkg::REG_GOAL_X])) - longint'(p.px);
        dy = longint'($signed(reg_copy[gtg_pkg::REG_GOAL_Y])) - longint'(p.py);
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        sq = {1'b0, ax * ax} + {1'b0, ay * ay};
        if (sq[64]) return 32'hffffffff;
        r = root64(sq[63:0]);
        return r > 64'hffffffff ? 32'hffffffff : r[31:0];
    endfunction

    function automatic longint yaw_of(t_pose p);
        longint qx, qy, qz, qw, n, m20;
        qx = p.qx; qy = p.qy; qz = p.qz; qw = p.qw;
        n = qx * qx + qy * qy + qz * qz + qw * qw;
        m20 = 2 * (qx * qz - qw * qy);
        if ((m20 < 0 ? -m20 : m20) >= n) return 0;
        return bearing_of(2 * (qx * qy + qw * qz), n - 2 * (qy * qy + qz * qz));
    endfunction

    // Works out the command for one accepted pose and advances the remembered state.
    function automatic t_cmd steer_predict(t_pose p);
        t_cmd c = '0;
        logic [31:0] d, tested;
        longint brg, err, ang, lim;
        longint unsigned lin;
        if (arrived) begin
            c.dst = prev_dist;
            c.done = 1'b1;
            return c;
        end
        d = range_to_goal(p);
        tested = prev_valid ? prev_dist : d;
        prev_valid = 1'b1;
        if (tested <= reg_copy[gtg_pkg::REG_TOL]) begin
            arrived = 1'b1;
            prev_dist = tested;
            c.dst = tested;
            c.done = 1'b1;
            return c;
        end
        prev_dist = d;
        brg = bearing_of(longint'($signed(reg_copy[gtg_pkg::REG_GOAL_Y])) - longint'(p.py),
                         longint'($signed(reg_copy[gtg_pkg::REG_GOAL_X])) - longint'(p.px));
        if (brg < 0) brg += QTWO_PI;
        err = brg - yaw_of(p);
        if (err > QPI) err -= QTWO_PI;
        lin = (longint'(reg_copy[gtg_pkg::REG_LIN_GAIN]) * longint'(d)) >> 16;
        if (lin > reg_copy[gtg_pkg::REG_LIN_LIM]) lin = reg_copy[gtg_pkg::REG_LIN_LIM];
        ang = (longint'(reg_copy[gtg_pkg::REG_HEAD_GAIN]) * err) >>> 16;
        lim = reg_copy[gtg_pkg::REG_ANG_LIM];
        if (ang > lim) ang = lim;
        if (ang < -lim) ang = -lim;
        c.lin = lin[19:0];
        c.ang = ang[20:0];
        c.dst = d;
        return c;
    endfunction

    function automatic int pick_gap();
        int r = $urandom_range(0, 99);
        if (calm || r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Source side: a new item may go out in the same step as the previous one is taken.
    int src_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (cur_row.typed) begin
                    void'(steer_predict(cur_row.pose));
                    cmd_q.push_back(cur_row.want);
                end else begin
                    cmd_q.push_back(steer_predict(cur_row.pose));
                end
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pose_q.size() > 0) begin
                    cur_row = pose_q.pop_front();
                    s_axis_tdata <= cur_row.pose;
                    s_axis_tvalid <= 1'b1;
                    src_gap <= pick_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Sink side: random stalls, each result checked against the oldest expectation.
    int snk_gap = 0;
    always @(posedge i_clk) begin
        t_cmd got, want;
        cycles <= cycles + 1;
        if (cycles > LIMIT_CY) begin
            $display("[FAIL] regression broken");
            $finish;
        end
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[73:0];
                if (cmd_q.size() == 0) begin
                    $display("%0t: unexpected item %h", $time, got);
                    errors++;
                end else begin
                    want = cmd_q.pop_front();
                    if (got.lin !== want.lin) begin
                        $display("%0t: linear_cmd exp %h got %h", $time, want.lin, got.lin);
                        errors++;
                    end
                    if (got.ang !== want.ang) begin
                        $display("%0t: angular_cmd exp %h got %h", $time, want.ang, got.ang);
                        errors++;
                    end
                    if (got.dst !== want.dst) begin
                        $display("%0t: goal_distance exp %h got %h", $time, want.dst, got.dst);
                        errors++;
                    end
                    if (got.done !== want.done) begin
                        $display("%0t: goal_done exp %b got %b", $time, want.done, got.done);
                        errors++;
                    end
                end
            end
            if (snk_gap > 0) begin
                snk_gap <= snk_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                snk_gap <= pick_gap();
            end
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] v);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        reg_copy[idx] = (idx == gtg_pkg::REG_GOAL_X || idx == gtg_pkg::REG_GOAL_Y) ? v
                        : {12'd0, v[19:0]};
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pose_q.size() != 0 || s_axis_tvalid || cmd_q.size() != 0);
        repeat (10) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_reg20();
        int r = $urandom_range(0, 9);
        if (r == 0) return 32'd0;
        if (r == 1) return 32'hfffff;
        if (r < 6) return $urandom_range(0, 32'h3ffff);
        return $urandom_range(0, 32'hfffff);
    endfunction

    function automatic logic signed [15:0] pick_quat();
        return 16'($urandom_range(0, 32768)) - 16'sd16384;
    endfunction

    // Keeps each random pose well outside any tolerance so that the done latch stays clear.
    function automatic t_pose far_pose();
        t_pose p;
        longint dx, dy;
        p.qx = pick_quat(); p.qy = pick_quat(); p.qz = pick_quat(); p.qw = pick_quat();
        do begin
            if ($urandom_range(0, 3) == 0) begin
                p.px = $urandom;
                p.py = $urandom;
            end else begin
                p.px = $signed(reg_copy[gtg_pkg::REG_GOAL_X])
                       + (32'($urandom_range(0, 32'hffffff)) - 32'sd8388608);
                p.py = $signed(reg_copy[gtg_pkg::REG_GOAL_Y])
                       + (32'($urandom_range(0, 32'hffffff)) - 32'sd8388608);
            end
            dx = longint'($signed(reg_copy[gtg_pkg::REG_GOAL_X])) - longint'(p.px);
            dy = longint'($signed(reg_copy[gtg_pkg::REG_GOAL_Y])) - longint'(p.py);
        end while ((dx < 0 ? -dx : dx) <= 2097152 && (dy < 0 ? -dy : dy) <= 2097152);
        return p;
    endfunction

    function automatic t_row row(logic signed [31:0] px, logic signed [31:0] py,
                                 logic signed [15:0] qx, logic signed [15:0] qy,
                                 logic signed [15:0] qz, logic signed [15:0] qw,
                                 bit typed = 1'b0, t_cmd want = '0);
        t_row r;
        r.pose = {qw, qz, qy, qx, py, px};
        r.typed = typed;
        r.want = want;
        return r;
    endfunction

    t_row opening [] = '{
        row(PMAX, PMIN, 0, 0, 0, 16384),
        row(PMIN, PMAX, 0, 0, 16384, 0),
        row(-196608, 0, 0, 0, 0, 0),
        row(0, -196608, 0, 0, 0, 0),
        row(0, 65536, 0, 11585, 0, 11585),
        row(65536, 0, 16384, 16384, 16384, 16384),
        row(0, -65536, -16384, -16384, -16384, -16384),
        row(1048576, 1048576, 0, 0, 11585, 11585),
        row(-1048576, 1048576, 0, 0, -11585, 11585),
        row(-1048576, -1048576, 16384, -16384, 16384, -16384),
        row(3278, 0, 0, 0, 16384, 16384),
        row(PMIN, PMIN, -16384, 0, 0, 0),
        row(PMAX, PMAX, 0, -16384, 0, 0),
        row(7, -5000, 1, -1, 2, -2)
    };

    // Pose on the goal gives a zero vector, the next item then arrives and latches done.
    t_row closing [] = '{
        row(0, 0, 0, 0, 0, 16384),
        row(PMAX, PMIN, 0, 0, 0, 16384, 1'b1, '{done: 1'b1, dst: 32'd0, ang: '0, lin: '0}),
        row(123, 456, 5, 6, 7, 8, 1'b1, '{done: 1'b1, dst: 32'd0, ang: '0, lin: '0})
    };

    initial begin
        reg_copy = '{32'd0, 32'd0, 32'(gtg_pkg::LIN_GAIN_RST), 32'(gtg_pkg::HEAD_GAIN_RST),
                     32'(gtg_pkg::LIN_LIM_RST), 32'(gtg_pkg::ANG_LIM_RST),
                     32'(gtg_pkg::TOL_RST)};
        prev_dist = '0;
        prev_valid = 1'b0;
        arrived = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening[k]) pose_q.push_back(opening[k]);
        wait_idle();

        for (int ph = 0; ph < 10; ph++) begin
            calm = (ph % 3 == 2);
            if (ph == 0) begin
                for (int k = 0; k < 7; k++) reg_write(3'(k), 32'd0);
            end else if (ph == 1) begin
                reg_write(gtg_pkg::REG_GOAL_X, 32'h7fffffff);
                reg_write(gtg_pkg::REG_GOAL_Y, 32'h80000000);
                for (int k = 2; k < 7; k++) reg_write(3'(k), 32'hfffff);
            end else begin
                reg_write(gtg_pkg::REG_GOAL_X, ph == 2 ? 32'h80000000 : $urandom);
                reg_write(gtg_pkg::REG_GOAL_Y, ph == 2 ? 32'h7fffffff : $urandom);
                reg_write(gtg_pkg::REG_LIN_GAIN, pick_reg20());
                reg_write(gtg_pkg::REG_HEAD_GAIN, pick_reg20());
                reg_write(gtg_pkg::REG_LIN_LIM, pick_reg20());
                reg_write(gtg_pkg::REG_ANG_LIM, pick_reg20());
                reg_write(gtg_pkg::REG_TOL, pick_reg20());
            end
            // Opposite corner from the goal; distance saturates for a corner goal.
            pose_q.push_back(row(reg_copy[gtg_pkg::REG_GOAL_X][31] ? PMAX : PMIN,
                                 reg_copy[gtg_pkg::REG_GOAL_Y][31] ? PMAX : PMIN,
                                 0, 0, 0, 16384));
            for (int k = 0; k < 194; k++) begin
                t_row r;
                r.pose = far_pose();
                r.typed = 1'b0;
                r.want = '0;
                pose_q.push_back(r);
            end
            wait_idle();
        end

        calm = 1'b0;
        for (int k = 0; k < 7; k++) reg_write(3'(k), 32'd0);
        reg_write(gtg_pkg::REG_TOL, 32'(gtg_pkg::TOL_RST));
        reg_write(gtg_pkg::REG_LIN_GAIN, 32'(gtg_pkg::LIN_GAIN_RST));
        foreach (closing[k]) pose_q.push_back(closing[k]);
        wait_idle();
        repeat (100) @(posedge i_clk);

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

/* go_to_goal_controller.f */
design/gtg_pkg.sv
design/gtg_cordic.sv
design/go_to_goal_controller.sv
design/gtg_checker.sv
tb/go_to_goal_controller_tb.sv
